FILE: rtl/all_pairs_shortest_path_assert.svh
// ---------------------------------------------------------------------------
// All-pairs shortest path: assertion macros
// Shared property wrappers for the concurrent checks of the block.
// ---------------------------------------------------------------------------
`ifndef ALL_PAIRS_SHORTEST_PATH_ASSERT_SVH
`define ALL_PAIRS_SHORTEST_PATH_ASSERT_SVH

// Same-cycle implication under synchronous reset.
`define APSP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("apsp assertion failed");

// Next-cycle implication under synchronous reset.
`define APSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("apsp assertion failed");

`endif

FILE: rtl/apsp_pkg.sv
// ---------------------------------------------------------------------------
// apsp_pkg
// Types, sizes and helpers shared by the all-pairs shortest path block.
// ---------------------------------------------------------------------------
package apsp_pkg;

   // Matrix side; a power of two so that an address is {row, column}.
   localparam int MAX_VERTICES = 16;
   localparam int VIDX_W       = $clog2(MAX_VERTICES);
   localparam int ADDR_W       = 2 * VIDX_W;
   localparam int DEPTH        = MAX_VERTICES * MAX_VERTICES;
   localparam int N_W          = $clog2(MAX_VERTICES + 1);
   localparam int CFG_W        = 5;
   localparam int VTX_W        = 4;
   localparam int COST_W       = 32;

   localparam logic [COST_W-1:0] COST_INF = '1;

   typedef enum logic [1:0] {
      FUNC_CLEAR = 2'd0,
      FUNC_ADD   = 2'd1,
      FUNC_SOLVE = 2'd2,
      FUNC_QUERY = 2'd3
   } func_type;

   typedef struct packed {
      func_type            func;
      logic [VTX_W-1:0]    src_vertex;
      logic [VTX_W-1:0]    dst_vertex;
      logic [COST_W-1:0]   edge_cost;
   } req_type;

   typedef struct packed {
      logic [COST_W-1:0]   distance;
      logic                reachable;
      logic                status;
   } rsp_type;

   typedef struct packed {
      logic                update;
      logic [COST_W-1:0]   sum;
   } relax_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_QRY_RD,
      ST_QRY_RSP,
      ST_REJECT,
      ST_SOLVE_ROW,
      ST_SOLVE_COL,
      ST_SOLVE_DONE
   } state_type;

   // Clamp the programmed vertex count to the matrix side.
   function automatic logic [N_W-1:0] eff_count(input logic [CFG_W-1:0] vc);
      logic [N_W-1:0] n;
      if (vc > MAX_VERTICES) begin
         n = N_W'(MAX_VERTICES);
      end else begin
         n = N_W'(vc);
      end
      return n;
   endfunction

endpackage

FILE: rtl/apsp_ram.sv
// ---------------------------------------------------------------------------
// apsp_ram
// Generic RAM: one write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
module apsp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a_ff <= mem[raddr_a];
      rdata_b_ff <= mem[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

FILE: rtl/apsp_relax.sv
// ---------------------------------------------------------------------------
// apsp_relax
// Shared add-and-compare unit: offers a + b when it fits in 32 bits and
// beats the current cost.
// ---------------------------------------------------------------------------
module apsp_relax (
   input  logic [apsp_pkg::COST_W-1:0] op_a,
   input  logic [apsp_pkg::COST_W-1:0] op_b,
   input  logic [apsp_pkg::COST_W-1:0] cur,
   output apsp_pkg::relax_type         result
);
   import apsp_pkg::*;

   logic [COST_W:0] sum_full;

   assign sum_full = {1'b0, op_a} + {1'b0, op_b};

   // Drop the relaxation on carry out.
   assign result.sum    = sum_full[COST_W-1:0];
   assign result.update = !sum_full[COST_W] && (sum_full[COST_W-1:0] < cur);

endmodule

FILE: rtl/all_pairs_shortest_path.sv
// ---------------------------------------------------------------------------
// all_pairs_shortest_path
// Distance matrix with clear, add edge, Floyd-Warshall solve and query.
// ---------------------------------------------------------------------------
// Usage:
//   Request: drive req_data and raise start; the request is taken at a clock
//   edge where start is high and busy is low. busy stays high until the
//   command's result has been produced.
//   Result: rsp_valid pulses for one cycle with rsp_data; every request gives
//   exactly one result. The receiver cannot stall; results are never held.
//   Config: csr_we with csr_wdata writes vertex_count; write only when idle.
//   Steps from the accepting edge to the registered result:
//     add edge: ST_ADD_RD, ST_ADD_WR; query: ST_QRY_RD, ST_QRY_RSP;
//     rejected index: ST_REJECT; clear: ST_CLEAR, one matrix entry written
//     per cycle over all 256 entries; solve: per (k, r) row of the n vertices
//     in use, ST_SOLVE_ROW fetches d[r][k] from the single matrix RAM, then
//     ST_SOLVE_COL runs one relaxation per cycle through the shared adder.
//   A new request may be taken in the cycle the previous result is shown.
//   Reset: vertex_count returns to 16 and the sequencer goes idle. The
//   matrix is not cleared by reset; issue a clear before anything else.
// ---------------------------------------------------------------------------
module all_pairs_shortest_path (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  apsp_pkg::req_type            req_data,
   output logic                         rsp_valid,
   output apsp_pkg::rsp_type            rsp_data,
   input  logic                         csr_we,
   input  logic [apsp_pkg::CFG_W-1:0]   csr_wdata
);
   import apsp_pkg::*;

   `include "all_pairs_shortest_path_assert.svh"

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [CFG_W-1:0]   vcount_ff;
   logic [VIDX_W-1:0]  k_ff, k_in;
   logic [VIDX_W-1:0]  r_ff, r_in;
   logic [VIDX_W-1:0]  c_ff, c_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [COST_W-1:0]  a_ff;
   logic               row_ld_ff, row_ld_in;
   logic               pipe_valid_ff, pipe_valid_in;
   logic [ADDR_W-1:0]  pipe_addr_ff, pipe_addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [N_W-1:0]     n_eff;
   logic [VIDX_W-1:0]  last_idx;
   logic               bad_index;
   logic               clr_last;
   logic [ADDR_W-1:0]  req_addr;

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [COST_W-1:0]  ram_wdata;
   logic [ADDR_W-1:0]  ram_raddr_a;
   logic [ADDR_W-1:0]  ram_raddr_b;
   logic [COST_W-1:0]  ram_rdata_a;
   logic [COST_W-1:0]  ram_rdata_b;

   logic [COST_W-1:0]  op_a;
   logic [COST_W-1:0]  op_b;
   relax_type          relax;

   assign n_eff     = eff_count(vcount_ff);
   assign last_idx  = VIDX_W'(n_eff - N_W'(1));
   assign bad_index = (req_data.src_vertex >= n_eff) || (req_data.dst_vertex >= n_eff);
   assign clr_last  = (clr_ff == ADDR_W'(DEPTH - 1));
   assign req_addr  = {VIDX_W'(req_ff.src_vertex), VIDX_W'(req_ff.dst_vertex)};

   apsp_ram #(
      .WIDTH (COST_W),
      .DEPTH (DEPTH)
   ) u_matrix (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (ram_waddr),
      .wdata   (ram_wdata),
      .raddr_a (ram_raddr_a),
      .raddr_b (ram_raddr_b),
      .rdata_a (ram_rdata_a),
      .rdata_b (ram_rdata_b)
   );

   // Add edge reuses the unit as cost + 0 against the stored entry.
   assign op_a = (state_ff == ST_ADD_WR) ? req_ff.edge_cost : a_ff;
   assign op_b = (state_ff == ST_ADD_WR) ? '0 : ram_rdata_a;

   apsp_relax u_relax (
      .op_a   (op_a),
      .op_b   (op_b),
      .cur    (ram_rdata_b),
      .result (relax)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_data.func)
                  FUNC_CLEAR: state_in = ST_CLEAR;
                  FUNC_SOLVE: state_in = (n_eff == '0) ? ST_SOLVE_DONE : ST_SOLVE_ROW;
                  FUNC_ADD:   state_in = bad_index ? ST_REJECT : ST_ADD_RD;
                  FUNC_QUERY: state_in = bad_index ? ST_REJECT : ST_QRY_RD;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_ADD_RD:    state_in = ST_ADD_WR;
         ST_ADD_WR:    state_in = ST_IDLE;
         ST_QRY_RD:    state_in = ST_QRY_RSP;
         ST_QRY_RSP:   state_in = ST_IDLE;
         ST_REJECT:    state_in = ST_IDLE;
         ST_SOLVE_ROW: state_in = ST_SOLVE_COL;
         ST_SOLVE_COL: begin
            if (c_ff == last_idx) begin
               if ((r_ff == last_idx) && (k_ff == last_idx)) begin
                  state_in = ST_SOLVE_DONE;
               end else begin
                  state_in = ST_SOLVE_ROW;
               end
            end
         end
         ST_SOLVE_DONE: state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Outputs, counters and RAM control
   always_comb begin
      req_in        = req_ff;
      k_in          = k_ff;
      r_in          = r_ff;
      c_in          = c_ff;
      clr_in        = clr_ff;
      row_ld_in     = 1'b0;
      pipe_valid_in = 1'b0;
      pipe_addr_in  = pipe_addr_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = '0;
      ram_raddr_a   = '0;
      ram_raddr_b   = req_addr;
      // Relaxation stage runs in the cycle after the read issue.
      ram_we        = pipe_valid_ff && relax.update;
      ram_waddr     = pipe_addr_ff;
      ram_wdata     = relax.sum;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               clr_in = '0;
               k_in   = '0;
               r_in   = '0;
               c_in   = '0;
            end
         end
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = (clr_ff[ADDR_W-1:VIDX_W] == clr_ff[VIDX_W-1:0]) ? '0 : COST_INF;
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_last) begin
               rsp_valid_in = 1'b1;
            end
         end
         ST_ADD_WR: begin
            ram_we       = relax.update;
            ram_waddr    = req_addr;
            ram_wdata    = relax.sum;
            rsp_valid_in = 1'b1;
         end
         ST_QRY_RSP: begin
            rsp_valid_in     = 1'b1;
            rsp_in.distance  = ram_rdata_b;
            rsp_in.reachable = (ram_rdata_b != COST_INF);
         end
         ST_REJECT: begin
            rsp_valid_in  = 1'b1;
            rsp_in.status = 1'b1;
         end
         ST_SOLVE_ROW: begin
            // Fetch d[r][k] for the row that follows.
            ram_raddr_a = {r_ff, k_ff};
            row_ld_in   = 1'b1;
            c_in        = '0;
         end
         ST_SOLVE_COL: begin
            ram_raddr_a   = {k_ff, c_ff};
            ram_raddr_b   = {r_ff, c_ff};
            pipe_valid_in = 1'b1;
            pipe_addr_in  = {r_ff, c_ff};
            c_in          = c_ff + VIDX_W'(1);
            if (c_ff == last_idx) begin
               if (r_ff == last_idx) begin
                  r_in = '0;
                  k_in = k_ff + VIDX_W'(1);
               end else begin
                  r_in = r_ff + VIDX_W'(1);
               end
            end
         end
         ST_SOLVE_DONE: begin
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         vcount_ff     <= CFG_W'(MAX_VERTICES);
         row_ld_ff     <= 1'b0;
         pipe_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         k_ff          <= '0;
         r_ff          <= '0;
         c_ff          <= '0;
         clr_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         row_ld_ff     <= row_ld_in;
         pipe_valid_ff <= pipe_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         k_ff          <= k_in;
         r_ff          <= r_in;
         c_ff          <= c_in;
         clr_ff        <= clr_in;
         if (csr_we) begin
            vcount_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      pipe_addr_ff <= pipe_addr_in;
      rsp_ff       <= rsp_in;
      // Hold d[r][k] for the whole row.
      if (row_ld_ff) begin
         a_ff <= ram_rdata_a;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `APSP_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `APSP_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_valid_ff, state_ff == ST_IDLE)
   `APSP_ASSERT_NOW(a_reject_zero, clock, reset, rsp_valid_ff && rsp_ff.status,
                    (rsp_ff.distance == '0) && !rsp_ff.reachable)
   `APSP_ASSERT_NOW(a_pipe_solve, clock, reset, pipe_valid_ff,
                    (state_ff == ST_SOLVE_ROW) || (state_ff == ST_SOLVE_COL) ||
                    (state_ff == ST_SOLVE_DONE))

endmodule

FILE: tb/all_pairs_shortest_path_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// all_pairs_shortest_path_tb
// Self-checking bench for the shortest path block. A behavioral copy of the
// distance matrix predicts the answer of every accepted request; a monitor
// compares each response strobe, field by field, against the oldest answer.
// Directed tests cover clear, edge merge, overflow on relaxation and index
// rejection; random phases build graphs, solve them and query them under
// varied vertex counts.
// ---------------------------------------------------------------------------
module all_pairs_shortest_path_tb;
   import apsp_pkg::*;

   localparam int RANDOM_ITEMS = 118;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [CFG_W-1:0] csr_wdata = '0;

   // Behavioral copy of the block state
   logic [COST_W-1:0] path_cost [MAX_VERTICES][MAX_VERTICES];
   logic [CFG_W-1:0]  vertex_setting = CFG_W'(MAX_VERTICES);

   rsp_type answer_q[$];
   rsp_type want;
   int      error_count = 0;
   int      random_sent = 0;
   bit      no_gaps = 1'b0;

   all_pairs_shortest_path dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Generous bound: far above the slowest run of this stimulus.
   initial begin
      #24_000_000;
      $display("[all_pairs_shortest_path] ERROR");
      $finish;
   end

   function automatic int unsigned vertices_in_use();
      int unsigned n;
      n = (vertex_setting > MAX_VERTICES) ? MAX_VERTICES : vertex_setting;
      return n;
   endfunction

   // Apply one command to the matrix copy and return its response.
   function automatic rsp_type shortest_path_answer(req_type r);
      rsp_type           a;
      int unsigned       n;
      logic [COST_W:0]   total;
      a = '0;
      n = vertices_in_use();
      case (r.func)
         FUNC_CLEAR: begin
            for (int i = 0; i < MAX_VERTICES; i++)
               for (int j = 0; j < MAX_VERTICES; j++)
                  path_cost[i][j] = (i == j) ? '0 : COST_INF;
         end
         FUNC_SOLVE: begin
            for (int k = 0; k < n; k++)
               for (int i = 0; i < n; i++)
                  for (int j = 0; j < n; j++) begin
                     total = {1'b0, path_cost[i][k]} + {1'b0, path_cost[k][j]};
                     // drop the relaxation when the sum carries out
                     if (!total[COST_W] && total[COST_W-1:0] < path_cost[i][j])
                        path_cost[i][j] = total[COST_W-1:0];
                  end
         end
         default: begin
            if (r.src_vertex >= n || r.dst_vertex >= n) begin
               a.status = 1'b1;
            end else if (r.func == FUNC_ADD) begin
               if (r.edge_cost < path_cost[r.src_vertex][r.dst_vertex])
                  path_cost[r.src_vertex][r.dst_vertex] = r.edge_cost;
            end else begin
               a.distance  = path_cost[r.src_vertex][r.dst_vertex];
               a.reachable = (a.distance != COST_INF);
            end
         end
      endcase
      return a;
   endfunction

   always @(negedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         if (answer_q.size() == 0) begin
            $display("%0t: response with no request outstanding: %h", $time, rsp_data);
            error_count++;
         end else begin
            want = answer_q.pop_front();
            if (rsp_data.distance !== want.distance) begin
               $display("%0t: distance expected %h actual %h",
                        $time, want.distance, rsp_data.distance);
               error_count++;
            end
            if (rsp_data.reachable !== want.reachable) begin
               $display("%0t: reachable expected %b actual %b",
                        $time, want.reachable, rsp_data.reachable);
               error_count++;
            end
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %b actual %b",
                        $time, want.status, rsp_data.status);
               error_count++;
            end
         end
      end
   end

   // Called at a rising edge; returns at the taking edge or after a gap.
   task automatic send_request(func_type f, int src, int dst, logic [COST_W-1:0] cost);
      req_type r;
      bit      taken;
      int      gap;
      r.func       = f;
      r.src_vertex = VTX_W'(src);
      r.dst_vertex = VTX_W'(dst);
      r.edge_cost  = cost;
      taken        = 1'b0;
      req_data <= r;
      start    <= 1'b1;
      while (!taken) begin
         @(negedge clock);
         taken = (busy === 1'b0);
         @(posedge clock);
      end
      answer_q.push_back(shortest_path_answer(r));
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold off until every response is back and the sequencer has settled.
   task automatic drain_answers();
      start <= 1'b0;
      while (answer_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_vertex_count(logic [CFG_W-1:0] value);
      drain_answers();
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      vertex_setting = value;
   endtask

   function automatic logic [COST_W-1:0] pick_cost();
      logic [COST_W-1:0] c;
      case ($urandom_range(0, 5))
         0:       c = '0;
         1, 2:    c = $urandom_range(1, 60);
         3:       c = COST_INF - $urandom_range(0, 15);
         default: c = $urandom;
      endcase
      return c;
   endfunction

   function automatic int pick_vertex();
      int unsigned n;
      n = vertices_in_use();
      return (n == 0) ? $urandom_range(0, 15) : $urandom_range(0, n - 1);
   endfunction

   task automatic test_clear_and_merge();
      send_request(FUNC_CLEAR, 0, 0, '0);
      send_request(FUNC_QUERY, 0, 0, '0);
      send_request(FUNC_QUERY, 15, 0, '0);
      send_request(FUNC_ADD, 0, 1, '0);
      send_request(FUNC_ADD, 0, 1, COST_INF);
      send_request(FUNC_ADD, 1, 2, 32'hFFFF_FFFE);
      send_request(FUNC_ADD, 2, 3, 32'd5);
      send_request(FUNC_ADD, 5, 5, 32'd9);
      send_request(FUNC_ADD, 15, 14, 32'h5A5A_A5A5);
      send_request(FUNC_QUERY, 0, 1, '0);
   endtask

   // Paths through the near-infinite edge that carry out must be skipped.
   task automatic test_solve_overflow();
      send_request(FUNC_SOLVE, 0, 0, '0);
      send_request(FUNC_QUERY, 0, 2, '0);
      send_request(FUNC_QUERY, 1, 3, '0);
      send_request(FUNC_QUERY, 15, 15, '0);
      drain_answers();
   endtask

   task automatic test_vertex_limits();
      write_vertex_count(CFG_W'(4));
      send_request(FUNC_ADD, 4, 0, 32'd1);
      send_request(FUNC_QUERY, 0, 15, '0);
      send_request(FUNC_SOLVE, 0, 0, '0);
      write_vertex_count('0);
      send_request(FUNC_ADD, 0, 0, 32'd3);
      send_request(FUNC_SOLVE, 0, 0, '0);
      send_request(FUNC_QUERY, 0, 0, '0);
      write_vertex_count(CFG_W'(1));
      // clear still covers the whole square with a single vertex in use
      send_request(FUNC_CLEAR, 0, 0, '0);
      send_request(FUNC_SOLVE, 0, 0, '0);
      write_vertex_count('1);
      send_request(FUNC_QUERY, 15, 14, '0);
      drain_answers();
   endtask

   task automatic test_random_graphs();
      int               arcs;
      int               asks;
      logic [CFG_W-1:0] count;
      while (random_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: count = CFG_W'($urandom_range(2, 6));
            6, 7:             count = CFG_W'($urandom_range(7, 16));
            8:                count = CFG_W'($urandom_range(17, 31));
            default:          count = CFG_W'($urandom_range(0, 1));
         endcase
         write_vertex_count(count);
         no_gaps = ($urandom_range(0, 2) == 0);
         if ($urandom_range(0, 3) != 0) begin
            send_request(FUNC_CLEAR, 0, 0, '0);
            random_sent++;
         end
         arcs = $urandom_range(3, 14);
         for (int i = 0; i < arcs; i++) begin
            if ($urandom_range(0, 6) == 0)
               send_request(func_type'($urandom_range(0, 3)), $urandom_range(0, 15),
                            $urandom_range(0, 15), $urandom);
            else
               send_request(FUNC_ADD, pick_vertex(), pick_vertex(), pick_cost());
            random_sent++;
         end
         send_request(FUNC_SOLVE, 0, 0, '0);
         random_sent++;
         asks = $urandom_range(3, 8);
         for (int i = 0; i < asks; i++) begin
            if ($urandom_range(0, 5) == 0)
               send_request(FUNC_QUERY, $urandom_range(0, 15), $urandom_range(0, 15), '0);
            else
               send_request(FUNC_QUERY, pick_vertex(), pick_vertex(), $urandom);
            random_sent++;
         end
      end
      drain_answers();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_clear_and_merge();
      test_solve_overflow();
      test_vertex_limits();
      test_random_graphs();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("[all_pairs_shortest_path] OK");
      else
         $display("[all_pairs_shortest_path] ERROR");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/apsp_pkg.sv
rtl/apsp_ram.sv
rtl/apsp_relax.sv
rtl/all_pairs_shortest_path.sv
tb/all_pairs_shortest_path_tb.sv
